// ===== sv/ascii_plist_format_sniffer_defines.svh =====
// ----------------------------------------------------------------------------
// ASCII property list sniffer assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASCII_PLIST_FORMAT_SNIFFER_DEFINES_SVH
`define ASCII_PLIST_FORMAT_SNIFFER_DEFINES_SVH

// same-cycle implication
`define APS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define APS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII property list sniffer package
// Verdict codes, character codes and character class helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aps_pkg;

  localparam logic [1:0] VerdictReject  = 2'd0;
  localparam logic [1:0] VerdictPlist   = 2'd1;
  localparam logic [1:0] VerdictStrings = 2'd2;

  localparam logic [2:0] PosLimit = 3'd4;

  localparam logic [7:0] CharNul       = 8'h00;
  localparam logic [7:0] CharNewline   = 8'h0a;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharDollar    = 8'h24;
  localparam logic [7:0] CharParen     = 8'h28;
  localparam logic [7:0] CharStar      = 8'h2a;
  localparam logic [7:0] CharDot       = 8'h2e;
  localparam logic [7:0] CharSlash     = 8'h2f;
  localparam logic [7:0] CharLess      = 8'h3c;
  localparam logic [7:0] CharEqual     = 8'h3d;
  localparam logic [7:0] CharQuestion  = 8'h3f;
  localparam logic [7:0] CharBang      = 8'h21;
  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharUnder     = 8'h5f;
  localparam logic [7:0] CharBrace     = 8'h7b;

  localparam logic [7:0] BomFe = 8'hfe;
  localparam logic [7:0] BomFf = 8'hff;
  localparam logic [7:0] BomEf = 8'hef;
  localparam logic [7:0] BomBb = 8'hbb;
  localparam logic [7:0] BomBf = 8'hbf;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_bom(input logic [7:0] c);
    return (c == BomFe) || (c == BomFf) || (c == BomEf) || (c == BomBb) ||
           (c == BomBf);
  endfunction

endpackage

// ===== sv/ascii_plist_format_sniffer.sv =====
// ----------------------------------------------------------------------------
// ASCII property list format sniffer
// Classifies a byte stream as reject, ASCII property list or strings format.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o | data_byte_i, final_byte_i
// out     | output    | out_valid_o/out_ready_i | verdict_o, decided_early_o
//
// One byte per cycle while in_ready_o is high; the scan state updates in the cycle of the transfer.
// The deciding byte's verdict is registered into the output register, or into the skid entry if that is still held.
// Output register plus one skid entry; in_ready_o drops only when both hold.
// Reset returns the scanner to its begin state with both output entries empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_plist_format_sniffer_defines.svh"

module ascii_plist_format_sniffer
  import aps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] verdict_o,
  output logic       decided_early_o
);

  typedef enum logic [2:0] {
    ScanBegin   = 3'd0,
    ScanComment = 3'd1,
    ScanLine    = 3'd2,
    ScanIdent   = 3'd3,
    ScanQuote   = 3'd4,
    ScanEqual   = 3'd5,
    ScanAngle   = 3'd6
  } scan_state_e;

  scan_state_e scan_q, scan_d, saved_q, saved_d;
  logic [7:0]  prev_q, prev_d;
  logic        bare_q, bare_d;
  logic [2:0]  pos_q, pos_d;
  logic        given_q, given_d;

  logic        out_valid_q, skid_valid_q;
  logic [1:0]  out_verdict_q, skid_verdict_q;
  logic        out_early_q, skid_early_q;

  logic        in_fire, pop, push;
  logic        res_valid, decided, res_early;
  logic [1:0]  res_verdict;
  logic        skip;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;
  assign push       = in_fire && res_valid;

  assign skip = (data_byte_i == CharNul) ||
                (is_space(data_byte_i) && (scan_q != ScanComment) &&
                 (scan_q != ScanLine) && (scan_q != ScanIdent));

  always_comb begin
    scan_d      = scan_q;
    saved_d     = saved_q;
    prev_d      = prev_q;
    bare_d      = bare_q;
    given_d     = given_q;
    pos_d       = (pos_q < PosLimit) ? pos_q + 3'd1 : pos_q;
    decided     = 1'b0;
    res_valid   = 1'b0;
    res_verdict = VerdictReject;
    res_early   = 1'b1;

    if (given_q) begin
    end else if (scan_q == ScanAngle) begin
      decided     = 1'b1;
      res_verdict = ((data_byte_i == CharQuestion) || (data_byte_i == CharBang)) ?
                    VerdictReject : VerdictPlist;
    end else if (skip) begin
    end else if (scan_q == ScanComment) begin
      if (data_byte_i == CharSlash) begin
        if (prev_q == CharStar) scan_d = saved_q;
        prev_d = CharNul;
      end else if (data_byte_i == CharStar) begin
        prev_d = CharStar;
      end else begin
        prev_d = CharNul;
      end
    end else if (scan_q == ScanLine) begin
      if (data_byte_i == CharNewline) begin
        scan_d = saved_q;
        prev_d = CharNul;
      end
    end else if (data_byte_i == CharSlash) begin
      if (prev_q == CharSlash) begin
        saved_d = scan_q;
        scan_d  = ScanLine;
        prev_d  = CharNul;
      end else if (prev_q != CharNul) begin
        decided = 1'b1;
      end else begin
        prev_d = CharSlash;
      end
    end else if (data_byte_i == CharStar) begin
      if (prev_q == CharSlash) begin
        saved_d = scan_q;
        scan_d  = ScanComment;
      end
      prev_d = CharNul;
    end else begin
      unique case (scan_q)
        ScanBegin: begin
          if (is_bom(data_byte_i)) begin
            decided = (pos_q >= PosLimit);
          end else if (data_byte_i == CharParen) begin
            decided     = 1'b1;
            res_verdict = VerdictPlist;
          end else if (data_byte_i == CharBrace) begin
            scan_d = ScanIdent;
          end else if (data_byte_i == CharLess) begin
            scan_d = ScanAngle;
          end else if (data_byte_i == CharQuote) begin
            bare_d = 1'b1;
            scan_d = ScanQuote;
          end else if (is_alnum(data_byte_i) || (data_byte_i == CharUnder) ||
                       (data_byte_i == CharDot) || (data_byte_i == CharDollar)) begin
            bare_d = 1'b1;
            scan_d = ScanIdent;
            prev_d = data_byte_i;
          end else begin
            decided = 1'b1;
          end
        end
        ScanIdent: begin
          if (is_space(data_byte_i) && (prev_q == CharNul)) begin
          end else if (data_byte_i == CharQuote) begin
            scan_d = ScanQuote;
          end else if (is_space(data_byte_i)) begin
            scan_d = ScanEqual;
            prev_d = CharNul;
          end else begin
            prev_d = data_byte_i;
          end
        end
        ScanQuote: begin
          if ((data_byte_i == CharQuote) && (prev_q != CharBackslash)) begin
            scan_d = ScanEqual;
            prev_d = CharNul;
          end else begin
            prev_d = data_byte_i;
          end
        end
        ScanEqual: begin
          decided = 1'b1;
          if (data_byte_i == CharEqual) begin
            res_verdict = bare_q ? VerdictStrings : VerdictPlist;
          end
        end
        default: begin
          decided = 1'b1;
        end
      endcase
    end

    if (!given_q) begin
      if (decided) begin
        res_valid = 1'b1;
      end else if (final_byte_i) begin
        res_valid = 1'b1;
        if (scan_d == ScanAngle) begin
          res_verdict = VerdictPlist;
        end else begin
          res_early = 1'b0;
          if ((scan_d == ScanEqual) && bare_d) res_verdict = VerdictPlist;
          else if (scan_d == ScanBegin)        res_verdict = VerdictStrings;
          else                                 res_verdict = VerdictReject;
        end
      end
      if (res_valid && !final_byte_i) given_d = 1'b1;
    end

    if (final_byte_i) begin
      scan_d  = ScanBegin;
      saved_d = ScanBegin;
      prev_d  = CharNul;
      bare_d  = 1'b0;
      pos_d   = 3'd0;
      given_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= ScanBegin;
      saved_q <= ScanBegin;
      prev_q  <= CharNul;
      bare_q  <= 1'b0;
      pos_q   <= 3'd0;
      given_q <= 1'b0;
    end else if (in_fire) begin
      scan_q  <= scan_d;
      saved_q <= saved_d;
      prev_q  <= prev_d;
      bare_q  <= bare_d;
      pos_q   <= pos_d;
      given_q <= given_d;
    end
  end

  // output register and skid entry: valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= skid_valid_q && push;
    end else if (!out_valid_q) begin
      out_valid_q  <= push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output register and skid entry: payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_verdict_q  <= skid_verdict_q;
        out_early_q    <= skid_early_q;
        skid_verdict_q <= res_verdict;
        skid_early_q   <= res_early;
      end else begin
        out_verdict_q  <= res_verdict;
        out_early_q    <= res_early;
      end
    end else if (!out_valid_q) begin
      out_verdict_q <= res_verdict;
      out_early_q   <= res_early;
    end else if (push) begin
      skid_verdict_q <= res_verdict;
      skid_early_q   <= res_early;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign verdict_o       = out_verdict_q;
  assign decided_early_o = out_early_q;

  `APS_ASSERT_SAME(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid entry holds a transfer while the output register is empty")
  `APS_ASSERT_NEXT(a_stall_to_skid, clk_i, rst_ni, out_valid_q && !out_ready_i && push, skid_valid_q, "stalled result was not held in the skid entry")
  `APS_ASSERT_NEXT(a_final_rearms, clk_i, rst_ni, in_fire && final_byte_i, (scan_q == ScanBegin) && !given_q && (pos_q == 3'd0) && !bare_q, "scanner did not re-arm after the last byte")
  `APS_ASSERT_SAME(a_one_verdict, clk_i, rst_ni, in_fire && given_q, !res_valid, "second verdict for one document")
  `APS_ASSERT_SAME(a_verdict_code, clk_i, rst_ni, out_valid_q, (out_verdict_q == VerdictReject) || (out_verdict_q == VerdictPlist) || (out_verdict_q == VerdictStrings), "undefined verdict code on the output")

endmodule
